// File: rtl/binary_to_seven_segment_frame_assert.svh
// ----------------------------------------------------------------------------
// Seven-segment frame builder - assertion macros
// Concurrent assertion wrappers, compiled away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_SEVEN_SEGMENT_FRAME_ASSERT_SVH
`define BINARY_TO_SEVEN_SEGMENT_FRAME_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define B2S_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define B2S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B2S_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define B2S_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/b2s_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder - package
// Shared command codes, controller/datapath interface types and segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package b2s_pkg;

    localparam int NUM_DIGITS = 8;

    // Input command codes
    localparam logic [1:0] CMD_CONV8  = 2'd0;
    localparam logic [1:0] CMD_CONV4  = 2'd1;
    localparam logic [1:0] CMD_EMIT   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Saturation limits
    localparam logic [31:0] MAX_EIGHT = 32'd99999999;
    localparam logic [31:0] MAX_FOUR  = 32'd9999;

    // Controller to datapath commands
    typedef struct packed {
        logic start_conv;
        logic four;
        logic step;
        logic store;
        logic start_emit;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic conv_last;
        logic plane_last;
        logic out_free;
    } t_dp_stat;

    // Decimal digit to segment byte (a in bit 7, point in bit 0)
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'hFC;
            4'd1: code = 8'h60;
            4'd2: code = 8'hDA;
            4'd3: code = 8'hF2;
            4'd4: code = 8'h66;
            4'd5: code = 8'hB6;
            4'd6: code = 8'h3E;
            4'd7: code = 8'hE0;
            4'd8: code = 8'hFE;
            4'd9: code = 8'hE6;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/binary_to_seven_segment_frame.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder - top level
// Binary to eight-digit seven-segment conversion and transposed frame output.
// ----------------------------------------------------------------------------
// Each input item carries a command. Convert-eight saturates the value to
// 99999999 and stores its eight decimal digits as segment bytes, digit 0 the
// most significant; convert-four saturates to 9999, blanks digits 0..3 and
// fills digits 4..7. Conversion is a bit-serial shift-add-3 loop over all 32
// value bits, so a convert item stalls the input through the accept, the
// shift loop and the store state, and produces no result. Update emits the
// stored 8x8 segment matrix transposed as eight writes, address k holding
// segment bit 7-k of every digit (digit 0 in bit 7), last set on the eighth;
// after acceptance it loads one write per cycle while the output is not
// stalled. An output register decouples the sides: a new item is taken
// as soon as the last write of a frame is loaded. Code 3 is dropped. After
// reset the display store is blank.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_seven_segment_frame_assert.svh"

module binary_to_seven_segment_frame
    import b2s_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_ram_address,
    output logic [7:0]       o_ram_data,
    output logic             o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic       w_in_take;
    logic       w_take_mid;
    logic [2:0] w_addr_inc;

    // Sequencer: idle, convert loop, store, emit
    b2s_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Converter, digit store, transpose and output register
    b2s_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_ram_address (o_ram_address),
        .o_ram_data    (o_ram_data),
        .o_last        (o_last)
    );

    // Handshake terms for the checks below
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_take_mid = o_out_valid && !i_out_stall && !o_last;
    assign w_addr_inc = o_ram_address + 3'd1;

    // The frame's final write always targets the last plane
    `B2S_ASSERT_SAME(a_last_addr, i_clk, i_rst_n, o_out_valid && o_last, o_ram_address == 3'd7)

    // A taken write that is not the last is followed at once by the next plane
    `B2S_ASSERT_NEXT(a_emit_cont, i_clk, i_rst_n, w_take_mid, o_out_valid)

    `B2S_ASSERT_NEXT(a_emit_addr, i_clk, i_rst_n, w_take_mid, o_ram_address == $past(w_addr_inc))

    // A taken valid command leaves the block busy in the following cycle
    `B2S_ASSERT_NEXT(a_busy, i_clk, i_rst_n, w_in_take && (i_cmd != CMD_UNUSED), o_in_stall)

endmodule

`default_nettype wire

// File: rtl/b2s_ctrl.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder - controller
// Sequences conversion, digit store and frame emission.
// ----------------------------------------------------------------------------
`default_nettype none

module b2s_ctrl
    import b2s_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd,
    output logic            o_in_stall,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_STORE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_CONV8: begin
                            o_cmd.start_conv = 1'b1;
                            n_state          = S_CONV;
                        end
                        CMD_CONV4: begin
                            o_cmd.start_conv = 1'b1;
                            o_cmd.four       = 1'b1;
                            n_state          = S_CONV;
                        end
                        CMD_EMIT: begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = S_EMIT;
                        end
                        default: begin
                            // drop unused code
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.load_out = i_stat.out_free;
                if (i_stat.out_free && i_stat.plane_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/b2s_dp.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder - datapath
// Serial shift-add-3 converter, digit segment store, plane transpose, output.
// ----------------------------------------------------------------------------
`default_nettype none

module b2s_dp
    import b2s_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_value,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic [2:0]       o_ram_address,
    output logic [7:0]       o_ram_data,
    output logic             o_last
);

    logic [31:0] r_bin;
    logic [31:0] r_bcd;
    logic [4:0]  r_cnt;
    logic        r_four;
    logic [2:0]  r_idx;
    logic [7:0]  r_seg [NUM_DIGITS];
    logic        r_out_valid;
    logic [2:0]  r_out_addr;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    logic [31:0] n_bin_sat;
    logic [31:0] n_bcd_adj;
    logic [7:0]  n_plane;

    // Saturate the incoming value for the chosen digit count
    always_comb begin
        if (i_cmd.four) begin
            n_bin_sat = (i_value > MAX_FOUR) ? MAX_FOUR : i_value;
        end else begin
            n_bin_sat = (i_value > MAX_EIGHT) ? MAX_EIGHT : i_value;
        end
    end

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Segment plane: digit d lands in bit 7-d
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            n_plane[7-d] = r_seg[d][3'd7 - r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_conv) begin
            r_bin  <= n_bin_sat;
            r_bcd  <= '0;
            r_cnt  <= '0;
            r_four <= i_cmd.four;
        end else if (i_cmd.step) begin
            r_bin <= {r_bin[30:0], 1'b0};
            r_bcd <= {n_bcd_adj[30:0], r_bin[31]};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_idx <= '0;
        end else if (i_cmd.load_out) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                r_seg[d] <= '0;
            end
        end else if (i_cmd.store) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (r_four && d < 4) begin
                    r_seg[d] <= '0;
                end else begin
                    r_seg[d] <= seg_code(r_bcd[4*(7-d) +: 4]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_addr <= r_idx;
            r_out_data <= n_plane;
            r_out_last <= (r_idx == 3'd7);
        end
    end

    assign o_stat.conv_last  = (r_cnt == 5'd31);
    assign o_stat.plane_last = (r_idx == 3'd7);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_ram_address = r_out_addr;
    assign o_ram_data    = r_out_data;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire
